### design/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// Depends on nothing; imported by mhpq_ctrl, the top module and the testbench.
package mhpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam int IN_TDATA_W  = ((KEY_WIDTH + 7) / 8) * 8;
    localparam int RES_W       = KEY_WIDTH + 1 + CNT_W + 2;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]           addr_t;
    typedef logic [CNT_W-1:0]            cnt_t;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef logic [1:0] err_t;
    localparam err_t ERR_NONE  = 2'd0;
    localparam err_t ERR_FULL  = 2'd1;
    localparam err_t ERR_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UP,
        ST_DOWN,
        ST_FINAL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        err_t error_code;
        cnt_t entry_count;
        logic is_empty;
        key_t top_key;
    } res_t;

endpackage

### design/mhpq_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module mhpq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### design/mhpq_ctrl.sv
// Heap sequencer: push sift-up and pop sift-down over the heap RAM.
// Depends on mhpq_pkg; drives the ports of mhpq_ram.
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  in_cmd,
    input  key_t  in_key,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res,
    output logic  mem_we,
    output addr_t mem_waddr,
    output key_t  mem_wdata,
    output logic  mem_re,
    output addr_t mem_raddr_a,
    output addr_t mem_raddr_b,
    input  key_t  mem_rdata_a,
    input  key_t  mem_rdata_b
);

    state_t state_reg, state_next;
    cnt_t   fill_reg, fill_next;
    addr_t  pos_reg, pos_next;
    key_t   key_reg, key_next;
    cnt_t   child_reg, child_next;
    err_t   err_reg, err_next;
    key_t   root_reg;

    // scratch for the current level
    addr_t             parent;
    cnt_t              right;
    logic              use_right;
    key_t              cval;
    cnt_t              cidx;
    logic [CNT_W:0]    next_left;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        key_reg   <= key_next;
        child_reg <= child_next;
        err_reg   <= err_next;
        // mirror of entry 0 for the result
        if (mem_we && mem_waddr == '0) begin
            root_reg <= mem_wdata;
        end
    end

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        child_next  = child_reg;
        err_next    = err_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = key_reg;
        mem_re      = 1'b0;
        mem_raddr_a = '0;
        mem_raddr_b = '0;

        parent    = addr_t'((pos_reg - addr_t'(1)) >> 1);
        right     = child_reg + cnt_t'(1);
        use_right = (right < fill_reg) && (mem_rdata_b < mem_rdata_a);
        cval      = use_right ? mem_rdata_b : mem_rdata_a;
        cidx      = use_right ? right : child_reg;
        next_left = {cidx, 1'b1};

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_cmd == CMD_PUSH) begin
                        if (fill_reg == cnt_t'(CAPACITY)) begin
                            err_next   = ERR_FULL;
                            state_next = ST_RESULT;
                        end else begin
                            err_next  = ERR_NONE;
                            fill_next = fill_reg + cnt_t'(1);
                            key_next  = in_key;
                            pos_next  = fill_reg[ADDR_W-1:0];
                            if (fill_reg == '0) begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = in_key;
                                state_next = ST_RESULT;
                            end else begin
                                mem_re      = 1'b1;
                                mem_raddr_a = addr_t'((fill_reg[ADDR_W-1:0] - addr_t'(1)) >> 1);
                                state_next  = ST_UP;
                            end
                        end
                    end else begin
                        if (fill_reg == '0) begin
                            err_next   = ERR_EMPTY;
                            state_next = ST_RESULT;
                        end else begin
                            err_next  = ERR_NONE;
                            fill_next = fill_reg - cnt_t'(1);
                            if (fill_reg == cnt_t'(1)) begin
                                state_next = ST_RESULT;
                            end else begin
                                // fetch the last entry, it moves to the root
                                mem_re      = 1'b1;
                                mem_raddr_a = addr_t'(fill_reg - cnt_t'(1));
                                state_next  = ST_LOAD;
                            end
                        end
                    end
                end
            end
            ST_LOAD: begin
                key_next = mem_rdata_a;
                pos_next = '0;
                if (fill_reg == cnt_t'(1)) begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = mem_rdata_a;
                    state_next = ST_RESULT;
                end else begin
                    mem_re      = 1'b1;
                    mem_raddr_a = addr_t'(1);
                    mem_raddr_b = addr_t'(2);
                    child_next  = cnt_t'(1);
                    state_next  = ST_DOWN;
                end
            end
            ST_UP: begin
                if (key_reg < mem_rdata_a) begin
                    // parent moves down into the hole
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_a;
                    pos_next  = parent;
                    if (parent == '0) begin
                        state_next = ST_FINAL;
                    end else begin
                        mem_re      = 1'b1;
                        mem_raddr_a = addr_t'((parent - addr_t'(1)) >> 1);
                    end
                end else begin
                    mem_we     = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_DOWN: begin
                if (cval < key_reg) begin
                    // smaller child moves up into the hole
                    mem_we    = 1'b1;
                    mem_wdata = cval;
                    pos_next  = cidx[ADDR_W-1:0];
                    if (next_left >= {1'b0, fill_reg}) begin
                        state_next = ST_FINAL;
                    end else begin
                        mem_re      = 1'b1;
                        mem_raddr_a = next_left[ADDR_W-1:0];
                        mem_raddr_b = next_left[ADDR_W-1:0] + addr_t'(1);
                        child_next  = next_left[CNT_W-1:0];
                    end
                end else begin
                    mem_we     = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_FINAL: begin
                mem_we     = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.top_key     = (fill_reg == '0) ? key_t'(0) : root_reg;
    assign res.is_empty    = (fill_reg == '0);
    assign res.entry_count = fill_reg;
    assign res.error_code  = err_reg;

endmodule

### design/min_heap_priority_queue.sv
// Min-heap priority queue of signed keys.
// Usage:
//   Slave channel: s_tuser is the command (0 push s_tdata, 1 pop minimum),
//   s_tdata the signed key. One word is taken at a time.
//   Master channel: one word per command with the minimum key, the empty
//   flag, the entry count and the error code (1 push while full, 2 pop while
//   empty; the heap is left unchanged in both cases).
// Timing: a push climbs the key level by level and a pop sinks the moved
//   entry level by level; each heap level costs one read of the heap RAM
//   (both children together on the way down) and one write back.
// The result sits in an output register; the next command is taken while it
//   waits, and a stalled receiver only holds the block once a second result
//   is ready.
// Reset clears the entry count and the pending result; heap RAM contents are
//   left as they are, since only filled entries are ever used.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_ram.
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // key
    input  logic                   s_tuser,  // cmd
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // top_key, is_empty, entry_count, error_code, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  mem_we;
    addr_t mem_waddr;
    key_t  mem_wdata;
    logic  mem_re;
    addr_t mem_raddr_a;
    addr_t mem_raddr_b;
    key_t  mem_rdata_a;
    key_t  mem_rdata_b;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    mhpq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_key      (key_t'(s_tdata[KEY_WIDTH-1:0])),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= OUT_TDATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### verif/tb.sv
// Self-checking testbench for min_heap_priority_queue: push/pop words in,
// one result word out per command, compared against a behavioral heap.
// Depends on mhpq_pkg and the min_heap_priority_queue RTL.
`timescale 1ns / 1ps

module tb;
    import mhpq_pkg::*;

    typedef struct {
        logic cmd;
        key_t key;
        logic typed;   // want is fixed by hand rather than taken from the heap model
        res_t want;
    } dir_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = CMD_PUSH;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // behavioral heap and the results it predicts
    key_t     model_keys [CAPACITY];
    int       model_fill = 0;
    res_t     pending_results [$];
    dir_row_t dir_rows [$];

    int words_sent  = 0;
    int words_seen  = 0;
    int fault_count = 0;

    min_heap_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic res_t mk_res(key_t top, logic empty, int cnt, err_t err);
        res_t r;
        r.top_key     = top;
        r.is_empty    = empty;
        r.entry_count = cnt_t'(cnt);
        r.error_code  = err;
        return r;
    endfunction

    // Apply one command to the behavioral heap and return the result word.
    function automatic res_t heap_apply(logic cmd, key_t k);
        int   pos;
        int   up;
        int   lc;
        int   rc;
        int   c;
        key_t t;
        res_t res;
        res.error_code = ERR_NONE;
        if (cmd == CMD_PUSH) begin
            if (model_fill >= CAPACITY) begin
                res.error_code = ERR_FULL;
            end else begin
                pos = model_fill;
                model_keys[pos] = k;
                model_fill++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (!(model_keys[pos] < model_keys[up]))
                        break;
                    t = model_keys[pos];
                    model_keys[pos] = model_keys[up];
                    model_keys[up] = t;
                    pos = up;
                end
            end
        end else begin
            if (model_fill == 0) begin
                res.error_code = ERR_EMPTY;
            end else begin
                model_fill--;
                model_keys[0] = model_keys[model_fill];
                pos = 0;
                forever begin
                    lc = 2 * pos + 1;
                    rc = lc + 1;
                    if (lc >= model_fill)
                        break;
                    c = lc;
                    // left child wins a tie
                    if (rc < model_fill && model_keys[rc] < model_keys[lc])
                        c = rc;
                    if (!(model_keys[c] < model_keys[pos]))
                        break;
                    t = model_keys[pos];
                    model_keys[pos] = model_keys[c];
                    model_keys[c] = t;
                    pos = c;
                end
            end
        end
        res.is_empty    = (model_fill == 0);
        res.entry_count = cnt_t'(model_fill);
        res.top_key     = (model_fill == 0) ? key_t'(0) : model_keys[0];
        return res;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(logic burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic key_t pick_key();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 3))
                    0: return key_t'(32'h8000_0000);
                    1: return key_t'(32'h7fff_ffff);
                    2: return key_t'(0);
                    default: return key_t'(-1);
                endcase
            end
            1, 2, 3: return key_t'($urandom_range(0, 15)) - key_t'(8);  // dense, many ties
            default: return key_t'($urandom);
        endcase
    endfunction

    task automatic send_word(logic cmd, key_t k, logic typed, res_t want);
        res_t pred;
        int   gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= k;
        do @(posedge aclk); while (!s_tready);
        pred = heap_apply(cmd, k);
        pending_results.push_back(typed ? want : pred);
        words_sent++;
        gap = pick_gap((words_sent % 256) < 48);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(int push_pct);
        logic cmd;
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        send_word(cmd, pick_key(), 1'b0, '0);
    endtask

    // Result receiver: random backpressure plus two long hold-offs that
    // back the block up into its input.
    initial begin
        int ready_gap;
        int hold_left;
        ready_gap = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (words_seen == 150 || words_seen == 1100)
                    hold_left = 400;
                else
                    ready_gap = pick_gap((words_seen % 300) < 60);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: unexpected result word top=%0d cnt=%0d err=%0d",
                             $realtime, got.top_key, got.entry_count, got.error_code);
            end else begin
                want = pending_results.pop_front();
                if (got.top_key !== want.top_key || got.is_empty !== want.is_empty ||
                    got.entry_count !== want.entry_count ||
                    got.error_code !== want.error_code) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"%0t: result mismatch exp top=%0d empty=%0b cnt=%0d err=%0d",
                                  " got top=%0d empty=%0b cnt=%0d err=%0d"}, $realtime,
                                 want.top_key, want.is_empty, want.entry_count,
                                 want.error_code, got.top_key, got.is_empty,
                                 got.entry_count, got.error_code);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        // pops carry junk keys to show the key is ignored
        dir_rows.push_back('{CMD_POP,  key_t'(32'h1234_5678), 1'b1,
                             mk_res(0, 1'b1, 0, ERR_EMPTY)});
        dir_rows.push_back('{CMD_PUSH, key_t'(32'h7fff_ffff), 1'b1,
                             mk_res(key_t'(32'h7fff_ffff), 1'b0, 1, ERR_NONE)});
        dir_rows.push_back('{CMD_PUSH, key_t'(32'h8000_0000), 1'b1,
                             mk_res(key_t'(32'h8000_0000), 1'b0, 2, ERR_NONE)});
        dir_rows.push_back('{CMD_PUSH, key_t'(0), 1'b1,
                             mk_res(key_t'(32'h8000_0000), 1'b0, 3, ERR_NONE)});
        dir_rows.push_back('{CMD_POP,  key_t'(-1), 1'b1, mk_res(0, 1'b0, 2, ERR_NONE)});
        dir_rows.push_back('{CMD_POP,  key_t'(5), 1'b1,
                             mk_res(key_t'(32'h7fff_ffff), 1'b0, 1, ERR_NONE)});
        dir_rows.push_back('{CMD_POP,  key_t'(0), 1'b1, mk_res(0, 1'b1, 0, ERR_NONE)});
        dir_rows.push_back('{CMD_POP,  key_t'(32'hffff_ffff), 1'b1,
                             mk_res(0, 1'b1, 0, ERR_EMPTY)});
        dir_rows.push_back('{CMD_PUSH, key_t'(-1), 1'b1, mk_res(key_t'(-1), 1'b0, 1, ERR_NONE)});
        // ties on both sift directions
        dir_rows.push_back('{CMD_PUSH, key_t'(5), 1'b0, '0});
        dir_rows.push_back('{CMD_PUSH, key_t'(5), 1'b0, '0});
        dir_rows.push_back('{CMD_PUSH, key_t'(-1), 1'b0, '0});
        dir_rows.push_back('{CMD_PUSH, key_t'(5), 1'b0, '0});
        dir_rows.push_back('{CMD_PUSH, key_t'(3), 1'b0, '0});
        dir_rows.push_back('{CMD_PUSH, key_t'(32'h8000_0000), 1'b0, '0});
        dir_rows.push_back('{CMD_PUSH, key_t'(32'h7fff_ffff), 1'b0, '0});
        dir_rows.push_back('{CMD_PUSH, key_t'(32'h5555_aaaa), 1'b0, '0});
        dir_rows.push_back('{CMD_POP,  key_t'(0), 1'b0, '0});
        dir_rows.push_back('{CMD_POP,  key_t'(0), 1'b0, '0});
        dir_rows.push_back('{CMD_POP,  key_t'(0), 1'b0, '0});
        dir_rows.push_back('{CMD_PUSH, key_t'(32'haaaa_5555), 1'b0, '0});
        dir_rows.push_back('{CMD_POP,  key_t'(0), 1'b0, '0});
        dir_rows.push_back('{CMD_POP,  key_t'(0), 1'b0, '0});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);

        // hover near empty, then fill to capacity, push into a full heap,
        // and drain a long way from full
        repeat (250) send_random(55);
        while (model_fill < CAPACITY)
            send_word(CMD_PUSH, pick_key(), 1'b0, '0);
        repeat (3) send_word(CMD_PUSH, pick_key(), 1'b0, '0);
        repeat (680) send_random(15);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
